// File: rtl/core/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by every module of the block except bsa_ram.
`default_nettype none

package bsa_pkg;

	localparam int IDX_W = 12;   // slot number on the input
	localparam int SLOT_W = 13;  // size register and first-free index

	localparam int DEF_MAX_BITS = 4096;
	localparam int DEF_WORD_BITS = 32;
	localparam int SIZE_RESET = 4096;

	localparam logic FUNC_SET = 1'b0;
	localparam logic FUNC_CLR = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_RESP
	} bsa_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture transaction, read its bitmap word
		logic set_err;    // result carries an error
		logic do_set;     // write word with slot bit set
		logic do_clear;   // write word with slot bit cleared
		logic scan_take;  // scan finished, update first-free and full
		logic scan_next;  // read the next bitmap word
		logic push;       // load the result register
	} bsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_err;
		logic is_clear;
		logic bit_used;
		logic need_scan;
		logic scan_done;
	} bsa_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bsa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/bsa_ctrl.sv
// Sequencing state machine for the bitmap slot allocator.
// Depends on bsa_pkg; drives bsa_dp through bsa_cmd_t.
`default_nettype none

module bsa_ctrl import bsa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire bsa_stat_t stat,
	output bsa_cmd_t       cmd
);

	bsa_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_OP;
				end
			end
			ST_OP: begin
				state_d = ST_RESP;
				if (stat.range_err || (stat.is_clear && !stat.bit_used)) begin
					cmd.set_err = 1'b1;
				end else if (stat.is_clear) begin
					cmd.do_clear = 1'b1;
				end else begin
					cmd.do_set = 1'b1;
					// setting the first free slot starts the search upward
					if (stat.need_scan) begin
						if (stat.scan_done) begin
							cmd.scan_take = 1'b1;
						end else begin
							cmd.scan_next = 1'b1;
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					cmd.scan_take = 1'b1;
					state_d = ST_RESP;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/bsa_dp.sv
// Datapath: size register, bitmap RAM with per-word valid bits, first-free
// scan and result register. Depends on bsa_pkg and bsa_ram.
`default_nettype none

module bsa_dp import bsa_pkg::*; #(
	parameter int MAX_BITS = DEF_MAX_BITS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SLOT_W-1:0] cfg_wdata,
	input  wire logic              func,
	input  wire logic [IDX_W-1:0]  bit_index,
	input  wire bsa_cmd_t          cmd,
	output bsa_stat_t              stat,
	output logic                   status,
	output logic      [SLOT_W-1:0] first_free,
	output logic                   is_full
);

	localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int CMP_W = (WA_W + BIT_W + 1 > SLOT_W) ? (WA_W + BIT_W + 1) : SLOT_W;
	localparam int SIZE_INIT = (SIZE_RESET > MAX_BITS) ? MAX_BITS : SIZE_RESET;

	logic [SLOT_W-1:0]    size_q;
	logic [SLOT_W-1:0]    lowest_q;
	logic                 full_q;
	logic [NUM_WORDS-1:0] valid_q;

	logic                 func_q;
	logic [IDX_W-1:0]     idx_q;
	logic [WA_W-1:0]      word_q;
	logic                 first_q;
	logic                 err_q;
	logic                 rd_valid_s1;

	logic                 status_q;
	logic [SLOT_W-1:0]    first_free_q;
	logic                 is_full_q;

	logic [CMP_W-1:0]     idx_ext;
	logic [WA_W-1:0]      in_word;
	logic [WA_W-1:0]      word_next;
	logic [WA_W-1:0]      rd_addr;
	logic                 rd_en;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] wr_word;
	logic                 wr_en;
	logic [BIT_W-1:0]     scan_start;
	logic [WORD_BITS-1:0] scan_src;
	logic [WORD_BITS-1:0] free_bits;
	logic                 hit;
	logic [BIT_W-1:0]     pos;
	logic [CMP_W-1:0]     cand;
	logic [CMP_W-1:0]     next_base;
	logic [CMP_W-1:0]     size_ext;
	logic                 cand_beyond;
	logic                 last_word;
	logic [SLOT_W-1:0]    scan_result;
	logic                 scan_full;

	assign idx_ext = CMP_W'(bit_index);
	assign in_word = WA_W'(idx_ext >> BIT_W);
	assign word_next = WA_W'(word_q + 1'b1);
	assign rd_en = cmd.load | cmd.scan_next;
	assign rd_addr = cmd.load ? in_word : word_next;

	// an unwritten word since the last clear reads as all free
	assign rd_word = rd_valid_s1 ? rdata : '0;
	assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_q[BIT_W-1:0];

	assign wr_en = cmd.do_set | cmd.do_clear;
	assign wr_word = cmd.do_set ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(word_q),
		.wdata(wr_word),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// The first word of a scan is the one just updated; search from the set
	// slot upward. Later words are searched from bit zero.
	assign scan_start = first_q ? idx_q[BIT_W-1:0] : '0;
	assign scan_src = first_q ? (rd_word | bit_mask) : rd_word;
	assign free_bits = ~scan_src & ({WORD_BITS{1'b1}} << scan_start);

	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				hit = 1'b1;
				pos = BIT_W'(i);
			end
		end
	end

	// bits at or above the size are never set, so a free bit found there
	// or running off the last word both mean the bitmap is full
	assign size_ext = CMP_W'(size_q);
	assign cand = (CMP_W'(word_q) << BIT_W) | CMP_W'(pos);
	assign next_base = (CMP_W'(word_q) + CMP_W'(1)) << BIT_W;
	assign cand_beyond = (cand >= size_ext);
	assign last_word = (next_base >= size_ext);
	assign scan_full = !hit || cand_beyond;
	assign scan_result = scan_full ? size_q : SLOT_W'(cand);

	assign stat.range_err = (SLOT_W'(idx_q) >= size_q);
	assign stat.is_clear = (func_q == FUNC_CLR);
	assign stat.bit_used = rd_word[idx_q[BIT_W-1:0]];
	assign stat.need_scan = (SLOT_W'(idx_q) == lowest_q);
	assign stat.scan_done = hit || last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SLOT_W'(SIZE_INIT);
			lowest_q <= '0;
			full_q <= 1'b0;
			valid_q <= '0;
		end else if (cfg_we) begin
			size_q <= (32'(cfg_wdata) > 32'(MAX_BITS)) ? SLOT_W'(MAX_BITS) : cfg_wdata;
			lowest_q <= '0;
			full_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (cmd.do_set) begin
				valid_q[word_q] <= 1'b1;
			end
			if (cmd.do_clear) begin
				full_q <= 1'b0;
				if (SLOT_W'(idx_q) < lowest_q) begin
					lowest_q <= SLOT_W'(idx_q);
				end
			end
			if (cmd.scan_take) begin
				lowest_q <= scan_result;
				full_q <= scan_full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			idx_q <= bit_index;
			word_q <= in_word;
			first_q <= 1'b1;
			err_q <= 1'b0;
		end
		if (cmd.scan_next) begin
			word_q <= word_next;
			first_q <= 1'b0;
		end
		if (cmd.set_err) begin
			err_q <= 1'b1;
		end
		if (rd_en) begin
			rd_valid_s1 <= valid_q[rd_addr];
		end
		if (cmd.push) begin
			status_q <= err_q ? STATUS_ERR : STATUS_OK;
			first_free_q <= lowest_q;
			is_full_q <= full_q;
		end
	end

	assign status = status_q;
	assign first_free = first_free_q;
	assign is_full = is_full_q;

endmodule

`default_nettype wire

// File: rtl/core/bitmap_slot_allocator.sv
// Bitmap slot allocator top level: controller plus datapath.
// Depends on bsa_pkg, bsa_ctrl, bsa_dp (which holds bsa_ram).
`default_nettype none

// Each transaction marks one slot used (func 0) or free (func 1) and returns
// one result: status, the lowest free slot and the full flag after the
// operation. A transaction is accepted, processed in the following cycle and
// its result registered in the response state once the output is free.
// Setting the slot that is currently first free searches upward one bitmap
// word per cycle through the single RAM read port before the response.
// The next transaction is taken as soon as the result is registered, even
// while it still waits at the output.
// Writing the size register clears the bitmap at once through per-word valid
// bits; there is no clearing pass after reset.
module bitmap_slot_allocator import bsa_pkg::*; #(
	parameter int MAX_BITS = DEF_MAX_BITS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SLOT_W-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              func,
	input  wire logic [IDX_W-1:0]  bit_index,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   status,
	output logic      [SLOT_W-1:0] first_free,
	output logic                   is_full
);

	bsa_cmd_t  cmd;
	bsa_stat_t stat;

	bsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	bsa_dp #(
		.MAX_BITS(MAX_BITS),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.func(func),
		.bit_index(bit_index),
		.cmd(cmd),
		.stat(stat),
		.status(status),
		.first_free(first_free),
		.is_full(is_full)
	);

endmodule

`default_nettype wire

// File: rtl/core/bsa_checker.sv
// Port-level assertions for bitmap_slot_allocator, bound to the top level.
// Depends on bsa_pkg.
`default_nettype none

module bsa_checker import bsa_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              status,
	input wire logic [SLOT_W-1:0] first_free,
	input wire logic              is_full
);

	// stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(first_free) && $stable(is_full))
		else $error("result changed while stalled");

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before result registered");

	// a result is only produced from a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a transaction in flight");

	// full only after a successful set, so the size is non-zero
	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_full |-> first_free != '0)
		else $error("full reported with first free slot zero");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

`default_nettype wire
